/* hw/rtl/wua_pkg.sv */
// wua_pkg: types and constants shared by the 256-bit alu files
// no dependencies
package wua_pkg;

  localparam int unsigned DataW = 256;
  localparam int unsigned LimbW = 64;
  localparam int unsigned CntW  = $clog2(DataW) + 1;
  localparam int unsigned ShW   = $clog2(DataW);

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0,
    ACT_SUB = 4'd1,
    ACT_MUL = 4'd2,
    ACT_DIV = 4'd3,
    ACT_SHL = 4'd4,
    ACT_SHR = 4'd5,
    ACT_AND = 4'd6,
    ACT_OR  = 4'd7,
    ACT_XOR = 4'd8,
    ACT_NOT = 4'd9,
    ACT_CMP = 4'd10
  } action_e;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [DataW-1:0] r;
    logic [DataW-1:0] rem;
    logic             dz;
    logic [1:0]       cc;
  } res_t;

endpackage

/* hw/rtl/wua_addsub.sv */
// wua_addsub: shared 257-bit adder / subtractor with carry out
// depends on wua_pkg
module wua_addsub (
  input  logic [wua_pkg::DataW:0] x_i,
  input  logic [wua_pkg::DataW:0] y_i,
  input  logic                    sub_i,
  output logic [wua_pkg::DataW:0] sum_o,
  output logic                    carry_o
);

  logic [wua_pkg::DataW:0]   y_eff;
  logic [wua_pkg::DataW+1:0] tot;

  assign y_eff   = sub_i ? ~y_i : y_i;
  assign tot     = {1'b0, x_i} + {1'b0, y_eff} + (wua_pkg::DataW+2)'(sub_i);
  assign sum_o   = tot[wua_pkg::DataW:0];
  assign carry_o = tot[wua_pkg::DataW+1];

endmodule

/* hw/rtl/wua_core.sv */
// wua_core: sequencer and operand registers around the shared adder
// depends on wua_pkg and wua_addsub
module wua_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  wua_pkg::action_e         action_i,
  input  logic [wua_pkg::DataW-1:0] a_i,
  input  logic [wua_pkg::DataW-1:0] b_i,
  input  logic                     out_free_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  output wua_pkg::res_t            res_o
);

  localparam int unsigned W = wua_pkg::DataW;

  wua_pkg::state_e  state_q, state_d;
  wua_pkg::action_e op_q, op_d;
  logic [W-1:0] acc_q, acc_d, x_q, x_d, y_q, y_d;
  logic [wua_pkg::CntW-1:0] cnt_q, cnt_d;
  logic dz_q, dz_d;
  logic [1:0] cc_q, cc_d;

  logic [W:0] u_x, u_y, u_sum;
  logic       u_sub, u_carry;
  logic       is_shift, b_zero;

  wua_addsub u_addsub (
    .x_i    (u_x),
    .y_i    (u_y),
    .sub_i  (u_sub),
    .sum_o  (u_sum),
    .carry_o(u_carry)
  );

  assign is_shift = (action_i == wua_pkg::ACT_SHL) || (action_i == wua_pkg::ACT_SHR);
  assign b_zero   = (b_i == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wua_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    cnt_q <= cnt_d;
    dz_q  <= dz_d;
    cc_q  <= cc_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    acc_d       = acc_q;
    x_d         = x_q;
    y_d         = y_q;
    cnt_d       = cnt_q;
    dz_d        = dz_q;
    cc_d        = cc_q;
    u_x         = {1'b0, x_q};
    u_y         = {1'b0, y_q};
    u_sub       = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      wua_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d    = action_i;
          dz_d    = (action_i == wua_pkg::ACT_DIV) && b_zero;
          x_d     = ((action_i == wua_pkg::ACT_DIV) && b_zero) ? '0 : a_i;
          y_d     = b_i;
          cc_d    = wua_pkg::CMP_LT;
          acc_d   = is_shift ? a_i : '0;
          cnt_d   = is_shift ? {1'b0, b_i[wua_pkg::ShW-1:0]} : wua_pkg::CntW'(W);
          state_d = wua_pkg::ST_EXEC;
        end
      end
      wua_pkg::ST_EXEC: begin
        case (op_q)
          wua_pkg::ACT_ADD: begin
            acc_d   = u_sum[W-1:0];
            state_d = wua_pkg::ST_FINISH;
          end
          wua_pkg::ACT_SUB: begin
            u_sub   = 1'b1;
            acc_d   = u_sum[W-1:0];
            state_d = wua_pkg::ST_FINISH;
          end
          wua_pkg::ACT_CMP: begin
            u_sub   = 1'b1;
            acc_d   = '0;
            if (!u_carry) begin
              cc_d = wua_pkg::CMP_LT;
            end else if (u_sum[W-1:0] == '0) begin
              cc_d = wua_pkg::CMP_EQ;
            end else begin
              cc_d = wua_pkg::CMP_GT;
            end
            state_d = wua_pkg::ST_FINISH;
          end
          wua_pkg::ACT_MUL: begin
            u_x = {1'b0, acc_q};
            u_y = {1'b0, x_q};
            if (y_q[0]) begin
              acc_d = u_sum[W-1:0];
            end
            x_d   = {x_q[W-2:0], 1'b0};
            y_d   = {1'b0, y_q[W-1:1]};
            cnt_d = cnt_q - 1'b1;
            if (cnt_q == wua_pkg::CntW'(1)) begin
              state_d = wua_pkg::ST_FINISH;
            end
          end
          wua_pkg::ACT_DIV: begin
            u_sub = 1'b1;
            u_x   = {acc_q, x_q[W-1]};
            u_y   = {1'b0, y_q};
            if (dz_q) begin
              state_d = wua_pkg::ST_FINISH;
            end else begin
              acc_d = u_carry ? u_sum[W-1:0] : {acc_q[W-2:0], x_q[W-1]};
              x_d   = {x_q[W-2:0], u_carry};
              cnt_d = cnt_q - 1'b1;
              if (cnt_q == wua_pkg::CntW'(1)) begin
                state_d = wua_pkg::ST_FINISH;
              end
            end
          end
          wua_pkg::ACT_SHL, wua_pkg::ACT_SHR: begin
            if (|y_q[W-1:wua_pkg::ShW]) begin
              acc_d   = '0;
              state_d = wua_pkg::ST_FINISH;
            end else if (cnt_q == '0) begin
              state_d = wua_pkg::ST_FINISH;
            end else begin
              acc_d = (op_q == wua_pkg::ACT_SHL) ? {acc_q[W-2:0], 1'b0}
                                                 : {1'b0, acc_q[W-1:1]};
              cnt_d = cnt_q - 1'b1;
            end
          end
          wua_pkg::ACT_AND: begin
            acc_d   = x_q & y_q;
            state_d = wua_pkg::ST_FINISH;
          end
          wua_pkg::ACT_OR: begin
            acc_d   = x_q | y_q;
            state_d = wua_pkg::ST_FINISH;
          end
          wua_pkg::ACT_XOR: begin
            acc_d   = x_q ^ y_q;
            state_d = wua_pkg::ST_FINISH;
          end
          wua_pkg::ACT_NOT: begin
            acc_d   = ~x_q;
            state_d = wua_pkg::ST_FINISH;
          end
          default: begin
            acc_d   = '0;
            state_d = wua_pkg::ST_FINISH;
          end
        endcase
      end
      wua_pkg::ST_FINISH: begin
        res_valid_o = out_free_i;
        if (out_free_i) begin
          state_d = wua_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wua_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle_o    = (state_q == wua_pkg::ST_IDLE);
  assign res_o.r   = (op_q == wua_pkg::ACT_DIV) ? x_q : acc_q;
  assign res_o.rem = (op_q == wua_pkg::ACT_DIV) ? acc_q : '0;
  assign res_o.dz  = dz_q;
  assign res_o.cc  = cc_q;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != wua_pkg::ST_IDLE) |-> !start_i)
    else $error("start while busy");
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wua_pkg::ST_EXEC && !dz_q &&
     (op_q == wua_pkg::ACT_MUL || op_q == wua_pkg::ACT_DIV)) |-> (cnt_q != '0))
    else $error("iteration count ran out");
  a_res_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == wua_pkg::ST_IDLE))
    else $error("no return to idle after result");
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (state_q == wua_pkg::ST_FINISH))
    else $error("result outside finish");
`endif

endmodule

/* hw/rtl/wide_uint256_alu_unit.sv */
// wide_uint256_alu_unit: top level of the 256-bit unsigned alu
// depends on wua_pkg and wua_core
//
// usage: one input word carries action and operands a, b as four 64-bit limbs;
// it is taken when in_valid_i is high and in_stall_o low. in_stall_o stays high
// while a word is being worked on. one output word per input word is shown
// on out_valid_o and held until out_stall_i is low.
// work from acceptance to the output register:
//   add, sub, compare, bitwise, not, unused codes: computed in the exec state
//   shifts: one bit position per exec step (count below 256), zero for larger counts
//   mul, divmod: one bit of b or of the quotient per cycle
//   through the shared 257-bit adder; divmod by zero skips the iteration
// throughput: one word at a time, next word accepted in the cycle after the
// result is loaded, even while that result still waits in the output register.
// reset clears the sequencer and the output valid; a stalled receiver holds
// the output word and the core waits in its finish state.
module wide_uint256_alu_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  action_i,
  input  logic [63:0] a_w0_i,
  input  logic [63:0] a_w1_i,
  input  logic [63:0] a_w2_i,
  input  logic [63:0] a_w3_i,
  input  logic [63:0] b_w0_i,
  input  logic [63:0] b_w1_i,
  input  logic [63:0] b_w2_i,
  input  logic [63:0] b_w3_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] r_w0_o,
  output logic [63:0] r_w1_o,
  output logic [63:0] r_w2_o,
  output logic [63:0] r_w3_o,
  output logic [63:0] rem_w0_o,
  output logic [63:0] rem_w1_o,
  output logic [63:0] rem_w2_o,
  output logic [63:0] rem_w3_o,
  output logic        div_zero_o,
  output logic [1:0]  cmp_code_o
);

  localparam int unsigned L = wua_pkg::LimbW;

  logic          core_idle, res_valid, out_free, start;
  wua_pkg::res_t res, out_q;
  logic          out_valid_q;

  assign in_stall_o = !core_idle;
  assign start      = in_valid_i && core_idle;
  assign out_free   = !out_valid_q || !out_stall_i;

  wua_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .action_i   (wua_pkg::action_e'(action_i)),
    .a_i        ({a_w3_i, a_w2_i, a_w1_i, a_w0_i}),
    .b_i        ({b_w3_i, b_w2_i, b_w1_i, b_w0_i}),
    .out_free_i (out_free),
    .idle_o     (core_idle),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign r_w0_o      = out_q.r[L-1:0];
  assign r_w1_o      = out_q.r[2*L-1:L];
  assign r_w2_o      = out_q.r[3*L-1:2*L];
  assign r_w3_o      = out_q.r[4*L-1:3*L];
  assign rem_w0_o    = out_q.rem[L-1:0];
  assign rem_w1_o    = out_q.rem[2*L-1:L];
  assign rem_w2_o    = out_q.rem[3*L-1:2*L];
  assign rem_w3_o    = out_q.rem[4*L-1:3*L];
  assign div_zero_o  = out_q.dz;
  assign cmp_code_o  = out_q.cc;

endmodule

/* dv/wide_uint256_alu_checker.sv */
// wide_uint256_alu_checker: watches both channels of the 256-bit alu, predicts each result
// word and compares it field by field; depends on wua_pkg
`timescale 1ns / 100ps
module wide_uint256_alu_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [3:0]  action_i,
  input  logic [63:0] a_w0_i,
  input  logic [63:0] a_w1_i,
  input  logic [63:0] a_w2_i,
  input  logic [63:0] a_w3_i,
  input  logic [63:0] b_w0_i,
  input  logic [63:0] b_w1_i,
  input  logic [63:0] b_w2_i,
  input  logic [63:0] b_w3_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] r_w0_i,
  input  logic [63:0] r_w1_i,
  input  logic [63:0] r_w2_i,
  input  logic [63:0] r_w3_i,
  input  logic [63:0] rem_w0_i,
  input  logic [63:0] rem_w1_i,
  input  logic [63:0] rem_w2_i,
  input  logic [63:0] rem_w3_i,
  input  logic        div_zero_i,
  input  logic [1:0]  cmp_code_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  wua_pkg::res_t alu_results_q[$];
  int fail_cnt = 0;

  function automatic wua_pkg::res_t alu_result(logic [3:0] act, logic [255:0] a,
                                               logic [255:0] b);
    wua_pkg::res_t res;
    logic [511:0] prod;
    res = '0;
    case (act)
      wua_pkg::ACT_ADD: res.r = a + b;
      wua_pkg::ACT_SUB: res.r = a - b;
      wua_pkg::ACT_MUL: begin
        prod = {256'd0, a} * {256'd0, b};
        res.r = prod[255:0];
      end
      wua_pkg::ACT_DIV: begin
        if (b == '0) res.dz = 1'b1;
        else begin
          res.r = a / b;
          res.rem = a % b;
        end
      end
      wua_pkg::ACT_SHL: if (b < 256) res.r = a << b[7:0];
      wua_pkg::ACT_SHR: if (b < 256) res.r = a >> b[7:0];
      wua_pkg::ACT_AND: res.r = a & b;
      wua_pkg::ACT_OR:  res.r = a | b;
      wua_pkg::ACT_XOR: res.r = a ^ b;
      wua_pkg::ACT_NOT: res.r = ~a;
      wua_pkg::ACT_CMP: res.cc = (a < b) ? wua_pkg::CMP_LT :
                                 ((a == b) ? wua_pkg::CMP_EQ : wua_pkg::CMP_GT);
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [255:0] exp_v, logic [255:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  assign fail_cnt_o = fail_cnt;

  always @(posedge clk_i) begin
    wua_pkg::res_t exp_r;
    if (rst_ni && in_valid_i && !in_stall_i)
      alu_results_q.push_back(alu_result(action_i, {a_w3_i, a_w2_i, a_w1_i, a_w0_i},
                                         {b_w3_i, b_w2_i, b_w1_i, b_w0_i}));
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (alu_results_q.size() == 0) begin
        $error("result word with none expected");
        fail_cnt++;
      end else begin
        exp_r = alu_results_q.pop_front();
        check_field("r", exp_r.r, {r_w3_i, r_w2_i, r_w1_i, r_w0_i});
        check_field("rem", exp_r.rem, {rem_w3_i, rem_w2_i, rem_w1_i, rem_w0_i});
        check_field("div_zero", exp_r.dz, div_zero_i);
        check_field("cmp_code", exp_r.cc, cmp_code_i);
      end
    end
    pending_o = alu_results_q.size();
  end
endmodule

/* dv/tb_wide_uint256_alu_unit.sv */
// tb_wide_uint256_alu_unit: directed and random stimulus for the 256-bit alu with random
// idling on both sides; depends on wua_pkg, the block and wide_uint256_alu_checker
`timescale 1ns / 100ps
module tb_wide_uint256_alu_unit;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] action_i;
  logic [255:0] a_v, b_v;
  logic [63:0] r_w0_o, r_w1_o, r_w2_o, r_w3_o, rem_w0_o, rem_w1_o, rem_w2_o, rem_w3_o;
  logic div_zero_o;
  logic [1:0] cmp_code_o;
  int fail_cnt, pending;
  bit no_idle;

  wide_uint256_alu_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i,
    .a_w0_i(a_v[63:0]), .a_w1_i(a_v[127:64]), .a_w2_i(a_v[191:128]), .a_w3_i(a_v[255:192]),
    .b_w0_i(b_v[63:0]), .b_w1_i(b_v[127:64]), .b_w2_i(b_v[191:128]), .b_w3_i(b_v[255:192]),
    .out_valid_o, .out_stall_i, .r_w0_o, .r_w1_o, .r_w2_o, .r_w3_o,
    .rem_w0_o, .rem_w1_o, .rem_w2_o, .rem_w3_o, .div_zero_o, .cmp_code_o
  );

  wide_uint256_alu_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i,
    .a_w0_i(a_v[63:0]), .a_w1_i(a_v[127:64]), .a_w2_i(a_v[191:128]), .a_w3_i(a_v[255:192]),
    .b_w0_i(b_v[63:0]), .b_w1_i(b_v[127:64]), .b_w2_i(b_v[191:128]), .b_w3_i(b_v[255:192]),
    .out_valid_i(out_valid_o), .out_stall_i, .r_w0_i(r_w0_o), .r_w1_i(r_w1_o),
    .r_w2_i(r_w2_o), .r_w3_i(r_w3_o), .rem_w0_i(rem_w0_o), .rem_w1_i(rem_w1_o),
    .rem_w2_i(rem_w2_o), .rem_w3_i(rem_w3_o), .div_zero_i(div_zero_o),
    .cmp_code_i(cmp_code_o), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_wide_uint256_alu_unit NOT OK");
    $finish;
  end

  always @(negedge clk_i) out_stall_i <= !no_idle && ($urandom_range(99) < 38);

  function automatic logic [255:0] rand_wide();
    logic [255:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      2: v = v >> $urandom_range(255);
      3: v = 256'd1 << $urandom_range(255);
      default: ;
    endcase
    return v;
  endfunction

  // valid drops only while idling, so back to back words keep it high
  task automatic send_word(logic [3:0] act, logic [255:0] a, logic [255:0] b);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    a_v <= a;
    b_v <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [3:0] act;
    logic [255:0] a, b;
    in_valid_i = 1'b0;
    action_i = '0;
    a_v = '0;
    b_v = '0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_word(wua_pkg::ACT_ADD, '1, 256'd1);
    send_word(wua_pkg::ACT_SUB, '0, 256'd1);
    send_word(wua_pkg::ACT_MUL, '1, '1);
    send_word(wua_pkg::ACT_DIV, '1, 256'd3);
    send_word(wua_pkg::ACT_DIV, 256'd5, '0);
    send_word(wua_pkg::ACT_DIV, 256'd5, '1);
    send_word(wua_pkg::ACT_SHL, '1, 256'd255);
    send_word(wua_pkg::ACT_SHL, '1, 256'd256);
    send_word(wua_pkg::ACT_SHR, '1, 256'd1);
    send_word(wua_pkg::ACT_SHR, '1, 256'd1 << 64);
    send_word(wua_pkg::ACT_AND, '1, 256'hf0);
    send_word(wua_pkg::ACT_OR, '0, '1);
    send_word(wua_pkg::ACT_XOR, '1, '1);
    send_word(wua_pkg::ACT_NOT, 256'd7, '1);
    send_word(wua_pkg::ACT_CMP, 256'd1, 256'd2);
    send_word(wua_pkg::ACT_CMP, '1, '1);
    send_word(wua_pkg::ACT_CMP, '1, '0);
    for (int k = 11; k < 16; k++) send_word(4'(k), '1, '1);
    for (int n = 0; n < 500; n++) begin
      if (n == 150) no_idle = 1'b1;
      if (n == 250) begin
        no_idle = 1'b0;
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      act = 4'($urandom_range(15));
      if ($urandom_range(9) != 0) act = 4'($urandom_range(10));
      a = rand_wide();
      b = rand_wide();
      if ((act == wua_pkg::ACT_SHL || act == wua_pkg::ACT_SHR) && $urandom_range(3) != 0)
        b = 256'($urandom_range(255));
      if (act == wua_pkg::ACT_CMP && $urandom_range(2) == 0) b = a;
      send_word(act, a, b);
    end
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_cnt == 0) $display("tb_wide_uint256_alu_unit OK");
    else $display("tb_wide_uint256_alu_unit NOT OK");
    $finish;
  end
endmodule
